>>> design/jlmp_pkg.sv
// ----------------------------------------------------------------------------
// jlmp_pkg: shared types, codes and helpers for the motion profile block
// Holds the value format, the request kinds, the register indexes, the
// sequencer states and the saturating helpers.
// ----------------------------------------------------------------------------
package jlmp_pkg;

	localparam int VW = 32;
	localparam int FB = 16;
	localparam int CW = VW - 1;

	typedef logic signed [VW-1:0] val_t;
	typedef logic [CW-1:0]        lim_t;
	typedef logic [FB-1:0]        dt_t;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_GOAL = 2'd1,
		KIND_LOAD = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_VEL_LIM  = 3'd0,
		REG_ACC_LIM  = 3'd1,
		REG_DEC_LIM  = 3'd2,
		REG_JERK_LIM = 3'd3,
		REG_POS_TOL  = 3'd4,
		REG_VEL_TOL  = 3'd5,
		REG_MIN_DT   = 3'd6,
		REG_MAX_DT   = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETCHK,
		ST_TICK0,
		ST_MVV,
		ST_MGG,
		ST_MBR,
		ST_TGT,
		ST_JRK,
		ST_MAV,
		ST_VNX,
		ST_MPS,
		ST_POS,
		ST_FIN,
		ST_EMIT
	} state_t;

	// Operands and sign request for the shared multiplier.
	typedef struct packed {
		logic [VW-1:0] a;
		logic [VW-1:0] b;
		logic          neg;
	} mul_req_t;

	localparam val_t VMAX = val_t'({1'b0, {CW{1'b1}}});
	localparam val_t VMIN = val_t'({1'b1, {CW{1'b0}}});

	// Saturate a value with two guard bits to the value range.
	function automatic val_t sat34(input logic signed [VW+1:0] x);
		val_t r;
		if (x > (VW+2)'(VMAX)) begin
			r = VMAX;
		end else if (x < (VW+2)'(VMIN)) begin
			r = VMIN;
		end else begin
			r = x[VW-1:0];
		end
		return r;
	endfunction

	// Negate when asked, saturating the single overflowing case.
	function automatic val_t neg_if(input val_t x, input logic n);
		logic signed [VW+1:0] e;
		e = (VW+2)'(x);
		return sat34(n ? -e : e);
	endfunction

	function automatic logic [VW:0] mag33(input logic signed [VW:0] x);
		return x[VW] ? (VW+1)'(-x) : (VW+1)'(x);
	endfunction

	function automatic logic [VW-1:0] mag32(input val_t x);
		return x[VW-1] ? VW'(-x) : VW'(x);
	endfunction

	function automatic val_t lim_val(input lim_t x);
		return val_t'({1'b0, x});
	endfunction

endpackage

>>> design/jlmp_mul.sv
// ----------------------------------------------------------------------------
// jlmp_mul: shared fixed-point multiplier
// Multiplies two magnitudes into a registered full product and derives the
// truncated, sign-applied and saturated fixed-point result from it.
// ----------------------------------------------------------------------------
module jlmp_mul (
	input  logic              clk,
	input  jlmp_pkg::mul_req_t req,
	output logic [63:0]       prod,
	output jlmp_pkg::val_t    q
);
	import jlmp_pkg::*;

	logic [2*VW-1:0] prod_s1;
	logic            neg_s1;
	logic [2*VW-FB-1:0] shr;
	logic [2*VW-FB-1:0] lim;
	logic [VW-1:0]   m;

	always_ff @(posedge clk) begin
		prod_s1 <= (2*VW)'(req.a) * (2*VW)'(req.b);
		neg_s1  <= req.neg;
	end

	// The negative side may reach one step further than the positive side.
	always_comb begin
		shr = prod_s1[2*VW-1:FB];
		lim = neg_s1 ? (2*VW-FB)'({1'b1, {CW{1'b0}}}) : (2*VW-FB)'({1'b0, {CW{1'b1}}});
		m   = (shr > lim) ? lim[VW-1:0] : shr[VW-1:0];
		q   = neg_s1 ? val_t'(-m) : val_t'(m);
	end

	assign prod = prod_s1;

endmodule

>>> design/jerk_limited_motion_profile.sv
// ----------------------------------------------------------------------------
// jerk_limited_motion_profile: S-curve motion profile generator
// Sequenced fixed-point profile step around one shared multiplier.
// ----------------------------------------------------------------------------
// The block holds a commanded position, velocity and acceleration (Q16.16)
// and a goal. Requests arrive on the s_axis channel: tuser carries the kind
// (tick, set goal, load state) and tdata the step time and operands. Every
// request yields exactly one response on m_axis with the state after it and
// the done flag.
// A tick runs through a sequencer that issues six products, one at a time,
// to a single 32 by 32 multiplier. Set goal and load state go through an
// arrival check, ignored or snapping ticks end after the first tick step
// and unused kinds go straight to the response. No new request is taken
// before the sequencer returns to idle as the response register is loaded,
// so the next request can be taken in the following cycle.
// s_axis_tready is high only while the sequencer is idle. A finished
// response sits in the output register, so the next request may be accepted
// while it waits; should a further response be due before the receiver has
// taken the last one, the sequencer holds until the register frees up.
// Configuration writes on the cfg channel are always taken; they are meant
// to occur only while the block is idle.
// Reset puts the state at rest at zero with done set, and loads the
// register defaults (unit limits, no jerk limit, zero tolerances).
// ----------------------------------------------------------------------------
module jerk_limited_motion_profile (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// step_time, goal_position, goal_velocity, load_position,
	// load_velocity, load_acceleration
	input  logic [175:0] s_axis_tdata,
	// kind
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// position, velocity, acceleration, done_res, zero padding
	output logic [103:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [30:0]  cfg_data
);
	import jlmp_pkg::*;

	state_t state_q, state_d;

	lim_t vel_lim_q, acc_lim_q, dec_lim_q, jerk_lim_q, pos_tol_q, vel_tol_q;
	dt_t  min_dt_q, max_dt_q;

	val_t cur_pos_q, cur_vel_q, cur_acc_q, tgt_pos_q, tgt_vel_q;
	logic done_q;

	// Per-tick working registers.
	dt_t  dt_q;
	logic dir_neg_q;
	val_t dx_pos_q, v_q, vg_q, a_q, vv_q, diff_q, a_tgt_q, a_next_q, v_next_q, v_avg_q;

	logic out_valid_q;
	logic [103:0] out_data_q;

	mul_req_t mreq;
	logic [63:0] mprod;
	val_t mq;

	jlmp_mul u_mul (
		.clk (clk),
		.req (mreq),
		.prod(mprod),
		.q   (mq)
	);

	logic accept;
	kind_t in_kind;
	assign accept  = s_axis_tvalid && s_axis_tready;
	assign in_kind = kind_t'(s_axis_tuser);

	// Arrival and direction logic on the current state.
	logic signed [VW:0] dx, dv;
	logic within_tol, dt_bad, has_dir, dir_neg;
	logic signed [VW+1:0] dirdx;
	always_comb begin
		dx = (VW+1)'(tgt_pos_q) - (VW+1)'(cur_pos_q);
		dv = (VW+1)'(tgt_vel_q) - (VW+1)'(cur_vel_q);
		within_tol = (mag33(dx) <= (VW+1)'(pos_tol_q)) && (mag33(dv) <= (VW+1)'(vel_tol_q));
		dt_bad = (dt_q < min_dt_q) || (dt_q > max_dt_q);
		has_dir = 1'b1;
		dir_neg = 1'b0;
		if (mag33(dx) > (VW+1)'(pos_tol_q)) begin
			dir_neg = dx[VW];
		end else if (mag33(dv) > (VW+1)'(vel_tol_q)) begin
			dir_neg = dv[VW];
		end else begin
			has_dir = 1'b0;
		end
		dirdx = dir_neg ? -(VW+2)'(dx) : (VW+2)'(dx);
	end

	// Braking decision and acceleration target.
	logic [63:0] lhs, rhs;
	logic brake;
	val_t a_tgt;
	always_comb begin
		lhs = {mprod[62:0], 1'b0};
		rhs = {16'd0, diff_q, 16'd0};
		if (v_q > vg_q) begin
			brake = (lhs <= rhs);
		end else begin
			brake = (dx_pos_q == '0);
		end
		if (v_q < 0) begin
			a_tgt = lim_val(acc_lim_q);
		end else if (brake) begin
			a_tgt = -lim_val(dec_lim_q);
		end else if (v_q < lim_val(vel_lim_q)) begin
			a_tgt = lim_val(acc_lim_q);
		end else begin
			a_tgt = '0;
		end
	end

	// Jerk-limited step of the acceleration.
	logic signed [VW+1:0] da, stp;
	val_t a_next;
	always_comb begin
		stp = (VW+2)'(mq);
		da  = (VW+2)'(a_tgt_q) - (VW+2)'(a_q);
		a_next = a_tgt_q;
		if (jerk_lim_q != '0) begin
			if (da > stp) begin
				a_next = sat34((VW+2)'(a_q) + stp);
			end else if (da < -stp) begin
				a_next = sat34((VW+2)'(a_q) - stp);
			end
		end
	end

	// Velocity update, clamp and average.
	val_t v_next, vlim;
	logic signed [VW:0] vsum;
	val_t v_avg;
	always_comb begin
		vlim   = lim_val(vel_lim_q);
		v_next = sat34((VW+2)'(v_q) + (VW+2)'(mq));
		if (v_next > vlim) begin
			v_next = vlim;
		end
		if (v_next < -vlim) begin
			v_next = -vlim;
		end
		vsum = (VW+1)'(v_q) + (VW+1)'(v_next);
		if (vsum < 0) begin
			v_avg = val_t'((vsum + (VW+1)'(1)) >>> 1);
		end else begin
			v_avg = val_t'(vsum >>> 1);
		end
	end

	val_t dva;
	logic overshoot;
	assign dva = dir_neg_q ? -v_avg_q : v_avg_q;
	assign overshoot = dir_neg_q ? (dx > 0) : (dx < 0);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_kind) inside
						KIND_TICK: state_d = ST_TICK0;
						KIND_GOAL, KIND_LOAD: state_d = ST_SETCHK;
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_SETCHK: state_d = ST_EMIT;
			ST_TICK0: begin
				if (done_q || dt_bad || vel_lim_q == '0 || !has_dir) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_MVV;
				end
			end
			ST_MVV: state_d = ST_MGG;
			ST_MGG: state_d = ST_MBR;
			ST_MBR: state_d = ST_TGT;
			ST_TGT: state_d = ST_JRK;
			ST_JRK: state_d = ST_MAV;
			ST_MAV: state_d = ST_VNX;
			ST_VNX: state_d = ST_MPS;
			ST_MPS: state_d = ST_POS;
			ST_POS: state_d = ST_FIN;
			ST_FIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: ready and the multiplier operands.
	always_comb begin
		s_axis_tready = 1'b0;
		mreq = '0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_MVV: mreq = '{a: mag32(v_q), b: mag32(v_q), neg: 1'b0};
			ST_MGG: mreq = '{a: mag32(vg_q), b: mag32(vg_q), neg: 1'b0};
			ST_MBR: mreq = '{a: VW'(dx_pos_q), b: VW'(dec_lim_q), neg: 1'b0};
			ST_TGT: mreq = '{a: VW'(jerk_lim_q), b: VW'(dt_q), neg: 1'b0};
			ST_MAV: mreq = '{a: mag32(a_next_q), b: VW'(dt_q), neg: a_next_q[VW-1]};
			ST_MPS: mreq = '{a: mag32(dva), b: VW'(dt_q), neg: dva[VW-1]};
			default: mreq = '0;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_lim_q  <= CW'(32'h0001_0000);
			acc_lim_q  <= CW'(32'h0001_0000);
			dec_lim_q  <= CW'(32'h0001_0000);
			jerk_lim_q <= '0;
			pos_tol_q  <= '0;
			vel_tol_q  <= '0;
			min_dt_q   <= FB'(1);
			max_dt_q   <= '1;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_VEL_LIM:  vel_lim_q  <= cfg_data;
				REG_ACC_LIM:  acc_lim_q  <= cfg_data;
				REG_DEC_LIM:  dec_lim_q  <= cfg_data;
				REG_JERK_LIM: jerk_lim_q <= cfg_data;
				REG_POS_TOL:  pos_tol_q  <= cfg_data;
				REG_VEL_TOL:  vel_tol_q  <= cfg_data;
				REG_MIN_DT:   min_dt_q   <= cfg_data[FB-1:0];
				REG_MAX_DT:   max_dt_q   <= cfg_data[FB-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cur_pos_q   <= '0;
			cur_vel_q   <= '0;
			cur_acc_q   <= '0;
			tgt_pos_q   <= '0;
			tgt_vel_q   <= '0;
			done_q      <= 1'b1;
		end else begin
			state_q <= state_d;
			// A new response may replace the one being taken in the same cycle.
			if (state_q == ST_EMIT && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_kind == KIND_GOAL) begin
						tgt_pos_q <= s_axis_tdata[47:16];
						tgt_vel_q <= s_axis_tdata[79:48];
						done_q    <= 1'b0;
					end else if (accept && in_kind == KIND_LOAD) begin
						cur_pos_q <= s_axis_tdata[111:80];
						cur_vel_q <= s_axis_tdata[143:112];
						cur_acc_q <= s_axis_tdata[175:144];
						done_q    <= 1'b0;
					end
				end
				ST_SETCHK: begin
					if (within_tol) begin
						cur_pos_q <= tgt_pos_q;
						cur_vel_q <= tgt_vel_q;
						cur_acc_q <= '0;
						done_q    <= 1'b1;
					end
				end
				ST_TICK0: begin
					if (!done_q && !dt_bad && (vel_lim_q == '0 || !has_dir)) begin
						cur_pos_q <= tgt_pos_q;
						cur_vel_q <= tgt_vel_q;
						cur_acc_q <= '0;
						done_q    <= 1'b1;
					end
				end
				ST_FIN: begin
					if (overshoot || within_tol) begin
						cur_pos_q <= tgt_pos_q;
						cur_vel_q <= tgt_vel_q;
						cur_acc_q <= '0;
						done_q    <= 1'b1;
					end
				end
				ST_POS: begin
					cur_pos_q <= sat34((VW+2)'(cur_pos_q) + (VW+2)'(mq));
					cur_vel_q <= neg_if(v_next_q, dir_neg_q);
					cur_acc_q <= neg_if(a_next_q, dir_neg_q);
				end
				default: ;
			endcase
		end
	end

	// Working registers and response payload need no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: dt_q <= s_axis_tdata[15:0];
			ST_TICK0: begin
				dir_neg_q <= dir_neg;
				dx_pos_q  <= (dirdx <= 0) ? val_t'(0) : sat34(dirdx);
				v_q       <= neg_if(cur_vel_q, dir_neg);
				vg_q      <= neg_if(tgt_vel_q, dir_neg);
				a_q       <= neg_if(cur_acc_q, dir_neg);
			end
			ST_MGG: vv_q <= mq;
			ST_MBR: diff_q <= (vv_q - mq < 0) ? val_t'(0) : vv_q - mq;
			ST_TGT: a_tgt_q <= a_tgt;
			ST_JRK: a_next_q <= a_next;
			ST_VNX: begin
				v_next_q <= v_next;
				v_avg_q  <= v_avg;
			end
			ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_data_q <= {7'd0, done_q, cur_acc_q, cur_vel_q, cur_pos_q};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// The block takes one request and is then busy until the response.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("request accepted while a previous one is being worked");

	// A response appears only out of the emit step.
	a_resp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
		else $error("response raised outside the emit step");

	// Once arrived, the commanded acceleration is at rest.
	a_done_at_rest: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> cur_acc_q == '0)
		else $error("done set with nonzero acceleration");

	// The final arrival check always hands over to the response.
	a_fin_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |=> state_q == ST_EMIT)
		else $error("sequencer skipped the response step");

endmodule

>>> test/tb_jerk_limited_motion_profile.sv
// ----------------------------------------------------------------------------
// tb_jerk_limited_motion_profile: self-checking bench for the profile block
// Requests are taken from a queue by a clocked driver. Every accepted
// request is run through a local fixed-point model of the profile step, and
// each response is compared with the oldest predicted state.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_jerk_limited_motion_profile;
	import jlmp_pkg::*;

	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;
	localparam int     STALL_LIMIT = 4000;
	localparam int     TAIL_CYCLES = 40;
	localparam int     ONE = 65536;

	// One request: the kind plus every operand field.
	typedef struct {
		kind_t       kind;
		logic [15:0] step;
		logic [31:0] gp, gv, lp, lv, la;
	} motion_req_t;

	// One response as the block reports it.
	typedef struct {
		logic [31:0] pos, vel, acc;
		logic        done;
	} motion_state_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [175:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [30:0]  cfg_data;

	jerk_limited_motion_profile dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Local copy of the registers and the motion state.
	longint      lim_vel, lim_acc, lim_dec, lim_jerk, tol_pos, tol_vel;
	longint      dt_min, dt_max;
	longint      pos_q, vel_q, acc_q, goal_p, goal_v;
	logic        at_goal;

	motion_req_t   req_queue[$];
	motion_state_t state_queue[$];

	int  errors;
	int  idle_cycles;
	int  send_gap;
	int  recv_stall;
	bit  no_idle;
	bit  req_taken;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Saturate to the 32-bit signed value range.
	function automatic longint clamp32(input longint x);
		if (x > SMAX) return SMAX;
		if (x < SMIN) return SMIN;
		return x;
	endfunction

	function automatic longint absval(input longint x);
		return x < 0 ? -x : x;
	endfunction

	// Q16.16 product, truncated toward zero and saturated.
	function automatic longint fx_mul(input longint a, input longint b);
		logic [127:0] p;
		logic [127:0] lim;
		logic         neg;
		neg = (a < 0) != (b < 0);
		p = {64'd0, absval(a)} * {64'd0, absval(b)};
		p = p >> 16;
		lim = neg ? 128'd2147483648 : 128'd2147483647;
		if (p > lim) p = lim;
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic bit near_goal();
		return absval(goal_p - pos_q) <= tol_pos && absval(goal_v - vel_q) <= tol_vel;
	endfunction

	function automatic void snap_to_goal();
		pos_q = goal_p;
		vel_q = goal_v;
		acc_q = 0;
		at_goal = 1'b1;
	endfunction

	// Braking is due when the remaining distance is inside the braking distance.
	function automatic bit brake_due(input longint dxp, input longint v, input longint vg);
		longint       diff;
		logic [127:0] lhs, rhs;
		diff = clamp32(fx_mul(v, v) - fx_mul(vg, vg));
		if (diff < 0) diff = 0;
		lhs = ({64'd0, dxp} * {64'd0, lim_dec}) << 1;
		rhs = {64'd0, diff} << 16;
		return lhs <= rhs;
	endfunction

	function automatic void profile_tick(input longint dt);
		longint dx, dv, dir, dxp, v, vg, a, a_tgt, a_nx, v_nx, v_avg, stp, da;
		if (at_goal) return;
		if (dt < dt_min || dt > dt_max) return;
		if (lim_vel == 0) begin
			snap_to_goal();
			return;
		end
		dx = goal_p - pos_q;
		dv = goal_v - vel_q;
		if (absval(dx) > tol_pos) begin
			dir = dx > 0 ? 1 : -1;
		end else if (absval(dv) > tol_vel) begin
			dir = dv > 0 ? 1 : -1;
		end else begin
			snap_to_goal();
			return;
		end
		dxp = clamp32(dir * dx);
		if (dxp < 0) dxp = 0;
		v = clamp32(dir * vel_q);
		vg = clamp32(dir * goal_v);
		a = clamp32(dir * acc_q);
		if (v < 0) begin
			a_tgt = lim_acc;
		end else if ((v > vg) ? brake_due(dxp, v, vg) : (dxp == 0)) begin
			a_tgt = -lim_dec;
		end else if (v < lim_vel) begin
			a_tgt = lim_acc;
		end else begin
			a_tgt = 0;
		end
		a_nx = a_tgt;
		if (lim_jerk != 0) begin
			stp = fx_mul(lim_jerk, dt);
			da = a_tgt - a;
			if (da > stp) a_nx = clamp32(a + stp);
			else if (da < -stp) a_nx = clamp32(a - stp);
		end
		v_nx = clamp32(v + fx_mul(a_nx, dt));
		if (v_nx > lim_vel) v_nx = lim_vel;
		if (v_nx < -lim_vel) v_nx = -lim_vel;
		v_avg = (v + v_nx) / 2;
		vel_q = clamp32(dir * v_nx);
		pos_q = clamp32(pos_q + fx_mul(dir * v_avg, dt));
		acc_q = clamp32(dir * a_nx);
		if (dir * (goal_p - pos_q) < 0) snap_to_goal();
		if (!at_goal && near_goal()) snap_to_goal();
	endfunction

	// Apply one request to the local state and return the state it leaves.
	function automatic motion_state_t profile_apply(input motion_req_t r);
		motion_state_t s;
		case (r.kind)
			KIND_TICK: begin
				profile_tick(longint'(r.step));
			end
			KIND_GOAL: begin
				goal_p = longint'($signed(r.gp));
				goal_v = longint'($signed(r.gv));
				at_goal = 1'b0;
				if (near_goal()) snap_to_goal();
			end
			KIND_LOAD: begin
				pos_q = longint'($signed(r.lp));
				vel_q = longint'($signed(r.lv));
				acc_q = longint'($signed(r.la));
				at_goal = 1'b0;
				if (near_goal()) snap_to_goal();
			end
			default: begin
			end
		endcase
		s.pos = pos_q[31:0];
		s.vel = vel_q[31:0];
		s.acc = acc_q[31:0];
		s.done = at_goal;
		return s;
	endfunction

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Driver: one request on the bus at a time, changes at the falling edge.
	always @(negedge clk) begin : driver
		logic        nv;
		motion_req_t r;
		if (arst_n) begin
			nv = s_axis_tvalid;
			if (req_taken) nv = 1'b0;
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (req_queue.size() > 0) begin
					r = req_queue.pop_front();
					s_axis_tdata <= {r.la, r.lv, r.lp, r.gv, r.gp, r.step};
					s_axis_tuser <= r.kind;
					nv = 1'b1;
					send_gap = pick_gap();
				end
			end
			s_axis_tvalid <= nv;
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_stall = pick_gap();
			end
		end
	end

	// Prediction on every accepted request.
	always @(posedge clk) begin : predictor
		motion_req_t r;
		req_taken <= s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			r.kind = kind_t'(s_axis_tuser);
			{r.la, r.lv, r.lp, r.gv, r.gp, r.step} = s_axis_tdata;
			state_queue.push_back(profile_apply(r));
		end
	end

	// Response check against the oldest prediction, plus the watchdog.
	always @(posedge clk) begin : monitor
		motion_state_t e;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (state_queue.size() == 0) begin
					$error("response with no request pending");
					errors++;
				end else begin
					e = state_queue.pop_front();
					if (m_axis_tdata[31:0] !== e.pos) begin
						$error("position expected %0d actual %0d", $signed(e.pos),
						       $signed(m_axis_tdata[31:0]));
						errors++;
					end
					if (m_axis_tdata[63:32] !== e.vel) begin
						$error("velocity expected %0d actual %0d", $signed(e.vel),
						       $signed(m_axis_tdata[63:32]));
						errors++;
					end
					if (m_axis_tdata[95:64] !== e.acc) begin
						$error("acceleration expected %0d actual %0d", $signed(e.acc),
						       $signed(m_axis_tdata[95:64]));
						errors++;
					end
					if (m_axis_tdata[96] !== e.done) begin
						$error("done_res expected %0d actual %0d", e.done,
						       m_axis_tdata[96]);
						errors++;
					end
				end
			end
		end
	end

	task automatic push_req(input kind_t k, input int step, input int gp, input int gv,
	                        input int lp, input int lv, input int la);
		motion_req_t r;
		r.kind = k;
		r.step = step[15:0];
		r.gp = gp;
		r.gv = gv;
		r.lp = lp;
		r.lv = lv;
		r.la = la;
		req_queue.push_back(r);
	endtask

	// Noise: any kind, every field fully random.
	task automatic push_noise();
		push_req(kind_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
		         $urandom, $urandom);
	endtask

	function automatic int rnd_small(input int range);
		return int'($urandom_range(0, 2 * range)) - range;
	endfunction

	// A well-formed move: set a goal, load a start, then tick towards it.
	task automatic push_move(input int ticks);
		int ext;
		ext = ($urandom_range(0, 9) == 0) ? 30000 * ONE : 6 * ONE;
		push_req(KIND_GOAL, $urandom, rnd_small(ext), rnd_small(ONE / 2), $urandom,
		         $urandom, $urandom);
		push_req(KIND_LOAD, $urandom, $urandom, $urandom, rnd_small(ext),
		         rnd_small(ONE), rnd_small(ONE));
		repeat (ticks) begin
			if ($urandom_range(0, 19) == 0) begin
				push_req(KIND_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
				         $urandom);
			end else begin
				push_req(KIND_TICK, $urandom_range(300, 16000), $urandom, $urandom,
				         $urandom, $urandom, $urandom);
			end
		end
	endtask

	// Let everything drain, including ignored ticks still in flight.
	task automatic wait_idle();
		while (req_queue.size() > 0 || s_axis_tvalid || state_queue.size() > 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [30:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_VEL_LIM:  lim_vel = longint'(value);
			REG_ACC_LIM:  lim_acc = longint'(value);
			REG_DEC_LIM:  lim_dec = longint'(value);
			REG_JERK_LIM: lim_jerk = longint'(value);
			REG_POS_TOL:  tol_pos = longint'(value);
			REG_VEL_TOL:  tol_vel = longint'(value);
			REG_MIN_DT:   dt_min = longint'(value[15:0]);
			REG_MAX_DT:   dt_max = longint'(value[15:0]);
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(input int vl, input int al, input int dl, input int jl,
	                          input int pt, input int vt, input int mn, input int mx);
		write_reg(REG_VEL_LIM, 31'(vl));
		write_reg(REG_ACC_LIM, 31'(al));
		write_reg(REG_DEC_LIM, 31'(dl));
		write_reg(REG_JERK_LIM, 31'(jl));
		write_reg(REG_POS_TOL, 31'(pt));
		write_reg(REG_VEL_TOL, 31'(vt));
		write_reg(REG_MIN_DT, 31'(mn));
		write_reg(REG_MAX_DT, 31'(mx));
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		send_gap = 0;
		recv_stall = 0;
		no_idle = 1'b0;
		req_taken = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = KIND_TICK;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_VEL_LIM;
		cfg_data = '0;
		lim_vel = ONE;
		lim_acc = ONE;
		lim_dec = ONE;
		lim_jerk = 0;
		tol_pos = 0;
		tol_vel = 0;
		dt_min = 1;
		dt_max = 65535;
		pos_q = 0;
		vel_q = 0;
		acc_q = 0;
		goal_p = 0;
		goal_v = 0;
		at_goal = 1'b1;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with the reset limits: a tick while done, the unused
		// kind, extreme operands, steps at and outside the accepted range.
		push_req(KIND_TICK, 1000, 0, 0, 0, 0, 0);
		push_req(KIND_NONE, 16'hffff, -1, -1, -1, -1, -1);
		push_req(KIND_GOAL, 0, 0, 0, 0, 0, 0);
		push_req(KIND_GOAL, 0, 32'sh7fffffff, 32'sh80000000, 0, 0, 0);
		push_req(KIND_TICK, 0, 0, 0, 0, 0, 0);
		push_req(KIND_TICK, 65535, 0, 0, 0, 0, 0);
		push_req(KIND_TICK, 1, 0, 0, 0, 0, 0);
		push_req(KIND_LOAD, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		push_req(KIND_TICK, 65535, 0, 0, 0, 0, 0);
		push_req(KIND_LOAD, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		push_req(KIND_TICK, 40000, 0, 0, 0, 0, 0);
		push_req(KIND_GOAL, 0, 2 * ONE, 0, 0, 0, 0);
		push_req(KIND_LOAD, 0, 0, 0, 0, 0, 0);
		repeat (8) push_req(KIND_TICK, 16384, 0, 0, 0, 0, 0);
		push_req(KIND_GOAL, 0, 0, 0, 0, 0, 0);
		push_req(KIND_LOAD, 0, 0, 0, -3 * ONE, -ONE, ONE);
		push_req(KIND_TICK, 8192, 0, 0, 0, 0, 0);
		wait_idle();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: set_limits(2 * ONE, ONE, 3 * ONE / 2, 4 * ONE, 256, 256, 1, 65535);
				1: set_limits(3 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0, 100, 20000);
				2: set_limits(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
				              0, 0, 0, 65535);
				3: set_limits(0, ONE, ONE, ONE, 0, 0, 0, 65535);
				// A zero braking limit brakes whenever above the goal velocity.
				4: set_limits(ONE, ONE, 0, ONE / 2, 16, 16, 1, 65535);
				// Minimum above maximum rejects every tick.
				5: set_limits(ONE, ONE, ONE, 0, 0, 0, 5000, 100);
				6: set_limits(ONE, ONE, ONE, 0, 32'sh7fffffff, 32'sh7fffffff, 1, 65535);
				default: set_limits($urandom_range(ONE / 4, 4 * ONE),
				                    $urandom_range(ONE / 4, 4 * ONE),
				                    $urandom_range(1, 4 * ONE),
				                    ($urandom_range(0, 1) ? $urandom_range(1, 8 * ONE) : 0),
				                    $urandom_range(0, 2000), $urandom_range(0, 2000),
				                    $urandom_range(1, 500), $urandom_range(10000, 65535));
			endcase
			no_idle = (ph % 3 == 2);
			while (req_queue.size() < 80) begin
				if ($urandom_range(0, 6) == 0) push_noise();
				else push_move($urandom_range(4, 30));
			end
			wait_idle();
		end

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
